// ===== hw/rtl/tlf_pkg.sv =====
// shared types and constants of the text line folder
`default_nettype none

package tlf_pkg;

	// input kinds carried in tuser
	localparam logic OP_CHAR  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// byte codes
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_HYPHEN = 8'd45;

	// line width limits
	localparam int         WIDTH_MIN   = 2;
	localparam int         WIDTH_CEIL  = 62;
	localparam logic [5:0] WIDTH_RESET = 6'd49;

	// emitter sequencer states
	typedef enum logic [1:0] {
		FOLD_IDLE,
		FOLD_READ,
		FOLD_HYPHEN,
		FOLD_NL
	} fold_state_t;

	// what follows the held bytes of one request
	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_NL,
		TAIL_HYPHEN_NL
	} tail_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlf_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module tlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/text_line_folder.sv =====
// top level of the text line folder
// Word-wrap line folder. Bytes arrive one per request on the slave stream
// (tuser = 0 for a character, 1 for a flush) and are held in a ring buffer
// of BUFFER_DEPTH bytes. A newline sends out the held line plus a newline; a
// flush sends out the held bytes with no newline. When the held count reaches
// the line width (cfg_data, saturated to 2 .. min(62, BUFFER_DEPTH)) the line
// folds at the last held space or tab, which is dropped, or, with no blank
// held, is cut with a hyphen and a newline. Output bytes leave on the master
// stream, tlast marking the final byte caused by one input request. A
// character that causes no output leaves the input side ready, so the next
// request is taken in the following cycle. A request that causes output
// stalls the input side until the emitter has launched its last byte,
// walking the ring through the single ram read port, one byte per cycle
// while the read stage is free; a stalled master stretches the stall. The
// ram read result and an output register form a two-deep pipeline, so the
// emitter keeps one byte per cycle under a ready master. The width register
// may be written at any time the block is idle and is taken in one cycle.
`default_nettype none

module text_line_folder
	import tlf_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// width register write channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [5:0] cfg_data,        // wrap_width
	// input stream
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,    // in_char
	input  wire logic       s_axis_tuser,    // opcode
	// output stream
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,    // out_char
	output logic            m_axis_tlast     // last_in_run
);

	localparam int AW   = $clog2(BUFFER_DEPTH);
	localparam int CW   = $clog2(BUFFER_DEPTH + 1);
	localparam int WTOP = (WIDTH_CEIL < BUFFER_DEPTH) ? WIDTH_CEIL : BUFFER_DEPTH;

	localparam logic [CW:0]   DEPTH_W   = (CW+1)'(BUFFER_DEPTH);
	localparam logic [CW-1:0] LAST_POS  = CW'(BUFFER_DEPTH - 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);

	// ring slot of the k-th held byte counted from base, k up to the depth
	function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
		input logic [CW-1:0] k);
		logic [CW:0] sum;
		sum = {{(CW+1-AW){1'b0}}, base} + {1'b0, k};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	// line state
	logic [5:0]    width_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] held_q;
	logic          blank_q;
	logic [AW-1:0] boff_q;

	// emitter sequencer
	fold_state_t   state_q, state_d;
	tail_t         tail_q;
	logic [CW-1:0] left_q;
	logic [AW-1:0] rd_addr_q;

	// read stage (ram output register) and output register
	logic          valid_s1;
	logic          ram_s1;
	logic [7:0]    char_s1;
	logic          last_s1;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_last_q;

	logic [7:0]    ram_rdata;

	// request decode and line update
	logic          accept;
	logic          is_char;
	logic          is_blank;
	logic [CW-1:0] eff_width;
	logic [CW-1:0] pos;
	logic [CW-1:0] new_count;
	logic          blank_d;
	logic [AW-1:0] boff_d;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;

	logic [AW-1:0] head_n;
	logic [CW-1:0] held_n;
	logic          blank_n;
	logic [AW-1:0] boff_n;
	logic [CW-1:0] plan_cnt;
	tail_t         plan_tail;

	// emitter controls
	logic          out_free;
	logic          s1_free;
	logic          issue;
	logic          issue_ram;
	logic [7:0]    issue_char;
	logic          issue_last;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == FOLD_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_char       = (s_axis_tuser == OP_CHAR) && (s_axis_tdata != CH_NL);
	assign is_blank      = (s_axis_tdata == CH_SPACE) || (s_axis_tdata == CH_TAB);

	// saturate the programmed width
	always_comb begin
		if (width_q < 6'(WIDTH_MIN)) begin
			eff_width = CW'(WIDTH_MIN);
		end else if (width_q > 6'(WTOP)) begin
			eff_width = CW'(WTOP);
		end else begin
			eff_width = CW'(width_q);
		end
	end

	// next line state and emission plan for the offered request
	always_comb begin
		pos       = (held_q >= LAST_POS) ? LAST_POS : held_q;
		new_count = pos + CW'(1);
		blank_d   = blank_q || is_blank;
		boff_d    = is_blank ? pos[AW-1:0] : boff_q;
		ram_we    = accept && is_char;
		ram_waddr = slot_f(head_q, pos);

		head_n    = '0;
		held_n    = '0;
		blank_n   = 1'b0;
		boff_n    = '0;
		plan_cnt  = held_q;
		plan_tail = TAIL_NONE;

		if (s_axis_tuser == OP_FLUSH) begin
			plan_tail = TAIL_NONE;
		end else if (!is_char) begin
			// newline ends the line
			plan_tail = TAIL_NL;
		end else if (new_count >= eff_width) begin
			if (blank_d) begin
				// fold at the last blank, drop it, keep the rest
				plan_cnt  = CW'(boff_d);
				plan_tail = TAIL_NL;
				head_n    = slot_f(head_q, CW'(boff_d) + CW'(1));
				held_n    = new_count - CW'(boff_d) - CW'(1);
			end else begin
				// no blank: hard cut with a hyphen
				plan_cnt  = new_count;
				plan_tail = TAIL_HYPHEN_NL;
			end
		end else begin
			// byte only joins the line
			plan_cnt  = '0;
			head_n    = head_q;
			held_n    = new_count;
			blank_n   = blank_d;
			boff_n    = boff_d;
		end
	end

	// emitter pipeline handshakes
	assign out_free = !out_valid_q || m_axis_tready;
	assign s1_free  = !valid_s1 || out_free;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FOLD_IDLE: begin
				if (accept) begin
					if (plan_cnt != '0) begin
						state_d = FOLD_READ;
					end else if (plan_tail == TAIL_NL) begin
						state_d = FOLD_NL;
					end else if (plan_tail == TAIL_HYPHEN_NL) begin
						state_d = FOLD_HYPHEN;
					end
				end
			end
			FOLD_READ: begin
				if (s1_free && (left_q == CW'(1))) begin
					case (tail_q)
						TAIL_NL:        state_d = FOLD_NL;
						TAIL_HYPHEN_NL: state_d = FOLD_HYPHEN;
						default:        state_d = FOLD_IDLE;
					endcase
				end
			end
			FOLD_HYPHEN: begin
				if (s1_free) begin
					state_d = FOLD_NL;
				end
			end
			FOLD_NL: begin
				if (s1_free) begin
					state_d = FOLD_IDLE;
				end
			end
			default: state_d = FOLD_IDLE;
		endcase
	end

	// sequencer outputs: one byte launched into the read stage per cycle while the read stage is free
	always_comb begin
		issue      = 1'b0;
		issue_ram  = 1'b0;
		issue_char = CH_NL;
		issue_last = 1'b0;
		unique case (state_q)
			FOLD_IDLE: begin
			end
			FOLD_READ: begin
				issue      = s1_free;
				issue_ram  = 1'b1;
				issue_last = (left_q == CW'(1)) && (tail_q == TAIL_NONE);
			end
			FOLD_HYPHEN: begin
				issue      = s1_free;
				issue_char = CH_HYPHEN;
			end
			FOLD_NL: begin
				issue      = s1_free;
				issue_char = CH_NL;
				issue_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// character ring
	tlf_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(s_axis_tdata),
		.re   (issue && issue_ram),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RESET;
			head_q      <= '0;
			held_q      <= '0;
			blank_q     <= 1'b0;
			boff_q      <= '0;
			state_q     <= FOLD_IDLE;
			tail_q      <= TAIL_NONE;
			left_q      <= '0;
			rd_addr_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				width_q <= cfg_data;
			end
			if (accept) begin
				head_q    <= head_n;
				held_q    <= held_n;
				blank_q   <= blank_n;
				boff_q    <= boff_n;
				tail_q    <= plan_tail;
				left_q    <= plan_cnt;
				rd_addr_q <= head_q;
			end else if (issue && issue_ram) begin
				left_q    <= left_q - CW'(1);
				rd_addr_q <= (rd_addr_q == LAST_SLOT) ? '0 : rd_addr_q + AW'(1);
			end
			if (s1_free) begin
				valid_s1 <= issue;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// payload of the read stage and output register
	always_ff @(posedge clk) begin
		if (issue) begin
			ram_s1  <= issue_ram;
			char_s1 <= issue_char;
			last_s1 <= issue_last;
		end
		if (out_free && valid_s1) begin
			out_char_q <= ram_s1 ? ram_rdata : char_s1;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
